// ===== rtl/core/mvsm_pkg.sv =====
// mvsm_pkg: shared types and constants for the multi-voice sample mixer
// no dependencies; imported by every module of the mixer
`timescale 1ns / 1ps

package mvsm_pkg;

   localparam int SAMPLE_WORDS = 16384;
   localparam int SOUNDS       = 16;
   localparam int ADDR_W       = 14;
   localparam int LEN_W        = 15;
   localparam int SID_W        = 4;
   localparam int GAIN_W       = 16;
   localparam int SAMPLE_W     = 16;
   localparam int MASK_W       = 8;
   localparam int STATUS_W     = 2;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_VOICE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_SOUND = 2'd2;

   // command classes after decode
   typedef enum logic [2:0] {
      FUNC_WRITE    = 3'd0,
      FUNC_DEFINE   = 3'd1,
      FUNC_PLAY     = 3'd2,
      FUNC_STOP     = 3'd3,
      FUNC_STOP_ALL = 3'd4,
      FUNC_TICK     = 3'd5,
      FUNC_NOP      = 3'd6
   } func_type;

   typedef struct packed {
      func_type                    func;
      logic [ADDR_W-1:0]           address;
      logic signed [SAMPLE_W-1:0]  left_sample;
      logic signed [SAMPLE_W-1:0]  right_sample;
      logic [SID_W-1:0]            sound_id;
      logic [LEN_W-1:0]            frame_count;
      logic                        repeat_req;
      logic [GAIN_W-1:0]           gain;
   } cmd_type;

endpackage

// ===== rtl/core/mvsm_front.sv =====
// mvsm_front: decodes incoming commands and holds them in a two-entry queue
// depends on mvsm_pkg
`timescale 1ns / 1ps

module mvsm_front
   import mvsm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [2:0]                 req_func,
   input  logic [ADDR_W-1:0]          req_address,
   input  logic signed [SAMPLE_W-1:0] req_left_sample,
   input  logic signed [SAMPLE_W-1:0] req_right_sample,
   input  logic [SID_W-1:0]           req_sound_id,
   input  logic [LEN_W-1:0]           req_frame_count,
   input  logic                       req_repeat_req,
   input  logic [GAIN_W-1:0]          req_volume,
   output logic                       cmd_valid,
   output cmd_type                    cmd,
   input  logic                       cmd_pop
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    dec;
   logic       push_ok;

   // classify the command and clamp the gain
   always_comb begin
      dec              = '0;
      dec.address      = req_address;
      dec.left_sample  = req_left_sample;
      dec.right_sample = req_right_sample;
      dec.sound_id     = req_sound_id;
      dec.frame_count  = req_frame_count;
      dec.repeat_req   = req_repeat_req;
      dec.gain         = (req_volume > GAIN_UNITY) ? GAIN_UNITY : req_volume;
      case (req_func)
         3'd0: dec.func = FUNC_WRITE;
         3'd1: dec.func = FUNC_DEFINE;
         3'd2: dec.func = FUNC_PLAY;
         3'd3: dec.func = FUNC_STOP;
         3'd4: dec.func = FUNC_STOP_ALL;
         3'd5: dec.func = FUNC_TICK;
         default: dec.func = FUNC_NOP;
      endcase
   end

   assign full      = (count_ff == 2'd2);
   assign push_ok   = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ===== rtl/core/mvsm_back.sv =====
// mvsm_back: executes commands against sample memory, sound table and voices
// depends on mvsm_pkg; holds the result register
`timescale 1ns / 1ps

module mvsm_back
   import mvsm_pkg::*;
#(
   parameter int VOICES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  cmd_type                    cmd,
   output logic                       cmd_pop,
   output logic                       empty,
   input  logic                       pop,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [MASK_W-1:0]          rsp_active_mask
);

   localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int SUM_W  = SAMPLE_W + $clog2(VOICES + 1);
   localparam int PROD_W = SUM_W + GAIN_W + 1;
   localparam int Q_W    = PROD_W - 15;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SOUND = 6'b000010,
      S_CHECK = 6'b000100,
      S_ACCUM = 6'b001000,
      S_SCALE = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [VW-1:0] voice_ff, voice_in;

   // voice and table state
   logic [VOICES-1:0] active_ff, active_in;
   logic [VOICES-1:0] loop_ff, loop_in;
   logic [SID_W-1:0]  vsound_ff [VOICES];
   logic [SID_W-1:0]  vsound_in [VOICES];
   logic [LEN_W-1:0]  vpos_ff [VOICES];
   logic [LEN_W-1:0]  vpos_in [VOICES];
   logic [SOUNDS-1:0] valid_ff, valid_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;

   // memories
   logic [2*SAMPLE_W-1:0] sample_mem [SAMPLE_WORDS];
   logic [ADDR_W-1:0]     start_mem [SOUNDS];
   logic [LEN_W-1:0]      len_mem [SOUNDS];
   logic [2*SAMPLE_W-1:0] sample_rd_ff;
   logic [ADDR_W-1:0]     start_rd_ff;
   logic [LEN_W-1:0]      len_rd_ff;
   logic                  mem_we, tbl_we;
   logic [ADDR_W-1:0]     mem_raddr;
   logic [SID_W-1:0]      tbl_raddr;

   // mix datapath
   logic signed [SUM_W-1:0]  lsum_ff, lsum_in, rsum_ff, rsum_in;
   logic signed [PROD_W-1:0] lprod_ff, lprod_in, rprod_ff, rprod_in;
   logic signed [Q_W-1:0]    lq, rq;

   // result register
   logic                       res_valid_ff;
   logic                       res_we;
   logic signed [SAMPLE_W-1:0] res_left_ff, res_left_in, res_right_ff, res_right_in;
   logic [STATUS_W-1:0]        res_status_ff, res_status_in;
   logic [MASK_W-1:0]          res_mask_ff, res_mask_in;
   logic                       out_free;

   logic              free_found;
   logic [VW-1:0]     free_idx;
   logic              voice_last;
   logic              pos_wrap;
   logic [LEN_W-1:0]  pos_use;

   assign out_free   = !res_valid_ff || pop;
   assign voice_last = (voice_ff == VW'(VOICES - 1));
   assign tbl_raddr  = vsound_ff[voice_ff];
   assign pos_wrap   = (vpos_ff[voice_ff] >= len_rd_ff);
   assign pos_use    = pos_wrap ? '0 : vpos_ff[voice_ff];
   assign mem_raddr  = start_rd_ff + pos_use[ADDR_W-1:0];

   // first free voice
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int v = VOICES - 1; v >= 0; v--) begin
         if (!active_ff[v]) begin
            free_found = 1'b1;
            free_idx   = VW'(v);
         end
      end
   end

   // scale results: floor shift and saturate
   assign lq = Q_W'(lprod_ff >>> 15);
   assign rq = Q_W'(rprod_ff >>> 15);

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [Q_W-1:0] q);
      logic signed [SAMPLE_W-1:0] r;
      if (q > Q_W'(32767)) begin
         r = 16'sh7FFF;
      end else if (q < -Q_W'(32768)) begin
         r = -16'sh8000;
      end else begin
         r = q[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      voice_in      = voice_ff;
      active_in     = active_ff;
      loop_in       = loop_ff;
      vsound_in     = vsound_ff;
      vpos_in       = vpos_ff;
      valid_in      = valid_ff;
      gain_in       = gain_ff;
      lsum_in       = lsum_ff;
      rsum_in       = rsum_ff;
      lprod_in      = lprod_ff;
      rprod_in      = rprod_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      tbl_we        = 1'b0;
      res_we        = 1'b0;
      res_left_in   = '0;
      res_right_in  = '0;
      res_status_in = STATUS_DONE;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               res_we  = 1'b1;
               case (cmd.func)
                  FUNC_WRITE: begin
                     mem_we = 1'b1;
                  end
                  FUNC_DEFINE: begin
                     tbl_we                 = 1'b1;
                     valid_in[cmd.sound_id] = 1'b1;
                  end
                  FUNC_PLAY: begin
                     if (!valid_ff[cmd.sound_id]) begin
                        res_status_in = STATUS_NO_SOUND;
                     end else begin
                        gain_in = cmd.gain;
                        if (free_found) begin
                           vsound_in[free_idx] = cmd.sound_id;
                           vpos_in[free_idx]   = '0;
                           loop_in[free_idx]   = cmd.repeat_req;
                           active_in[free_idx] = 1'b1;
                        end else begin
                           res_status_in = STATUS_NO_VOICE;
                        end
                     end
                  end
                  FUNC_STOP: begin
                     if (!valid_ff[cmd.sound_id]) begin
                        res_status_in = STATUS_NO_SOUND;
                     end else begin
                        for (int v = 0; v < VOICES; v++) begin
                           if (vsound_ff[v] == cmd.sound_id) begin
                              active_in[v] = 1'b0;
                           end
                        end
                     end
                  end
                  FUNC_STOP_ALL: begin
                     active_in = '0;
                  end
                  FUNC_TICK: begin
                     res_we   = 1'b0;
                     voice_in = '0;
                     lsum_in  = '0;
                     rsum_in  = '0;
                     state_in = S_SOUND;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SOUND: begin
            if (active_ff[voice_ff]) begin
               state_in = S_CHECK;
            end else if (voice_last) begin
               state_in = S_SCALE;
            end else begin
               voice_in = voice_ff + 1'b1;
            end
         end
         S_CHECK: begin
            if (pos_wrap && !loop_ff[voice_ff]) begin
               active_in[voice_ff] = 1'b0;
               if (voice_last) begin
                  state_in = S_SCALE;
               end else begin
                  voice_in = voice_ff + 1'b1;
                  state_in = S_SOUND;
               end
            end else begin
               vpos_in[voice_ff] = pos_use + 1'b1;
               state_in          = S_ACCUM;
            end
         end
         S_ACCUM: begin
            lsum_in = lsum_ff + SUM_W'($signed(sample_rd_ff[2*SAMPLE_W-1:SAMPLE_W]));
            rsum_in = rsum_ff + SUM_W'($signed(sample_rd_ff[SAMPLE_W-1:0]));
            if (voice_last) begin
               state_in = S_SCALE;
            end else begin
               voice_in = voice_ff + 1'b1;
               state_in = S_SOUND;
            end
         end
         S_SCALE: begin
            lprod_in = PROD_W'(lsum_ff) * PROD_W'($signed({1'b0, gain_ff}));
            rprod_in = PROD_W'(rsum_ff) * PROD_W'($signed({1'b0, gain_ff}));
            state_in = S_DONE;
         end
         S_DONE: begin
            res_left_in  = sat16(lq);
            res_right_in = sat16(rq);
            if (out_free) begin
               res_we   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // active mask after the step, first eight voices only
   always_comb begin
      res_mask_in = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (i < VOICES) begin
            res_mask_in[i] = active_in[i % VOICES];
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         voice_ff     <= '0;
         active_ff    <= '0;
         loop_ff      <= '0;
         valid_ff     <= '0;
         gain_ff      <= GAIN_UNITY;
         res_valid_ff <= 1'b0;
         for (int v = 0; v < VOICES; v++) begin
            vsound_ff[v] <= '0;
            vpos_ff[v]   <= '0;
         end
      end else begin
         state_ff  <= state_in;
         voice_ff  <= voice_in;
         active_ff <= active_in;
         loop_ff   <= loop_in;
         valid_ff  <= valid_in;
         gain_ff   <= gain_in;
         vsound_ff <= vsound_in;
         vpos_ff   <= vpos_in;
         if (res_we) begin
            res_valid_ff <= 1'b1;
         end else if (pop) begin
            res_valid_ff <= 1'b0;
         end
      end
   end

   // datapath and result payload
   always_ff @(posedge clock) begin
      lsum_ff  <= lsum_in;
      rsum_ff  <= rsum_in;
      lprod_ff <= lprod_in;
      rprod_ff <= rprod_in;
      if (res_we) begin
         res_left_ff   <= res_left_in;
         res_right_ff  <= res_right_in;
         res_status_ff <= res_status_in;
         res_mask_ff   <= res_mask_in;
      end
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[cmd.address] <= {cmd.left_sample, cmd.right_sample};
      end
      sample_rd_ff <= sample_mem[mem_raddr];
   end

   // sound table
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         start_mem[cmd.sound_id] <= cmd.address;
         len_mem[cmd.sound_id]   <= cmd.frame_count;
      end
      start_rd_ff <= start_mem[tbl_raddr];
      len_rd_ff   <= len_mem[tbl_raddr];
   end

   assign empty           = !res_valid_ff;
   assign rsp_left_out    = res_left_ff;
   assign rsp_right_out   = res_right_ff;
   assign rsp_status      = res_status_ff;
   assign rsp_active_mask = res_mask_ff;

endmodule

// ===== rtl/core/multi_voice_sample_mixer_core.sv =====
// multi_voice_sample_mixer_core: stereo eight-voice PCM playback mixer
// depends on mvsm_pkg, mvsm_front and mvsm_back
//
// Usage: commands enter through a queue port (push/full, req_* fields) and
// each gives exactly one result through a queue port (empty/pop, rsp_*).
// A command is transferred when push is high and full is low; the result
// on rsp_* is transferred when pop is high and empty is low.
// Commands wait in a two-entry queue ahead of the executor, so the sender
// keeps going while a result is held. Write, define, play, stop, stop all
// and unused codes complete in the executor's idle state, which loads the
// result register directly. A tick walks the voices in turn: an idle voice
// is only checked, an active voice passes through sound table read, sample
// memory read and accumulate, then gain scaling and saturation follow.
// When the receiver stalls, the result register holds and the executor
// waits; the queue then fills and full rises.
// Reset clears voices, sound valid bits and the queue and sets unity gain;
// sample memory and sound table contents are undefined until written.
`timescale 1ns / 1ps

module multi_voice_sample_mixer_core
   import mvsm_pkg::*;
#(
   parameter int VOICES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [2:0]                 req_func,
   input  logic [ADDR_W-1:0]          req_address,
   input  logic signed [SAMPLE_W-1:0] req_left_sample,
   input  logic signed [SAMPLE_W-1:0] req_right_sample,
   input  logic [SID_W-1:0]           req_sound_id,
   input  logic [LEN_W-1:0]           req_frame_count,
   input  logic                       req_repeat_req,
   input  logic [GAIN_W-1:0]          req_volume,
   output logic                       empty,
   input  logic                       pop,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [MASK_W-1:0]          rsp_active_mask
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // decode and command queue
   mvsm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_func         (req_func),
      .req_address      (req_address),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_sound_id     (req_sound_id),
      .req_frame_count  (req_frame_count),
      .req_repeat_req   (req_repeat_req),
      .req_volume       (req_volume),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   // executor and result register
   mvsm_back #(
      .VOICES (VOICES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_left_out    (rsp_left_out),
      .rsp_right_out   (rsp_right_out),
      .rsp_status      (rsp_status),
      .rsp_active_mask (rsp_active_mask)
   );

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for multi_voice_sample_mixer_core
// depends on mvsm_pkg and the mixer RTL; keeps its own mixer model in step with the DUT
`timescale 1ns / 1ps

module testbench;
   import mvsm_pkg::*;

   localparam int NUM_VOICES = 8;
   localparam logic [2:0] FUNC_SPARE = 3'd7;
   localparam int RANDOM_ITEMS = 1700;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic [1:0]         status;
      logic [7:0]         mask;
   } mix_result_type;

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic pop = 0;
   logic full, empty;
   logic [2:0]                 req_func = 0;
   logic [ADDR_W-1:0]          req_address = 0;
   logic signed [SAMPLE_W-1:0] req_left_sample = 0;
   logic signed [SAMPLE_W-1:0] req_right_sample = 0;
   logic [SID_W-1:0]           req_sound_id = 0;
   logic [LEN_W-1:0]           req_frame_count = 0;
   logic                       req_repeat_req = 0;
   logic [GAIN_W-1:0]          req_volume = 0;
   logic signed [SAMPLE_W-1:0] rsp_left_out, rsp_right_out;
   logic [STATUS_W-1:0]        rsp_status;
   logic [MASK_W-1:0]          rsp_active_mask;

   // model of the mixer state
   logic [31:0]       store [SAMPLE_WORDS];
   bit                written [SAMPLE_WORDS];
   logic [ADDR_W-1:0] snd_start [SOUNDS];
   logic [LEN_W-1:0]  snd_len [SOUNDS];
   bit                snd_valid [SOUNDS];
   bit                v_active [NUM_VOICES];
   bit                v_loop [NUM_VOICES];
   logic [SID_W-1:0]  v_sound [NUM_VOICES];
   logic [LEN_W-1:0]  v_pos [NUM_VOICES];
   int                gain;

   mix_result_type pending_mix [$];
   bit        failed = 0;
   bit        sender_idle = 1;
   bit        receiver_idle = 1;
   int        pop_hold = 0;
   bit        pop_hold_req = 0;
   int        sent_count = 0;

   multi_voice_sample_mixer_core DUT (
      .clock, .reset, .push, .full,
      .req_func, .req_address, .req_left_sample, .req_right_sample,
      .req_sound_id, .req_frame_count, .req_repeat_req, .req_volume,
      .empty, .pop, .rsp_left_out, .rsp_right_out, .rsp_status, .rsp_active_mask
   );

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("** multi_voice_sample_mixer_core: FAILED **");
      $finish;
   end

   // scale a channel sum by the master gain with floor and saturation
   function automatic logic signed [15:0] scale_channel(longint sum);
      longint q;
      q = (sum * gain) >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   // advance the model by one command and return its result
   function automatic mix_result_type mix_step(cmd_type c);
      mix_result_type r;
      longint lsum, rsum;
      logic [LEN_W-1:0] pos;
      logic [ADDR_W-1:0] a;
      r.left = 0;
      r.right = 0;
      r.status = STATUS_DONE;
      case (c.func)
         FUNC_WRITE: begin
            store[c.address] = {c.left_sample, c.right_sample};
            written[c.address] = 1;
         end
         FUNC_DEFINE: begin
            snd_start[c.sound_id] = c.address;
            snd_len[c.sound_id] = c.frame_count;
            snd_valid[c.sound_id] = 1;
         end
         FUNC_PLAY: begin
            if (!snd_valid[c.sound_id]) begin
               r.status = STATUS_NO_SOUND;
            end else begin
               gain = (c.gain > GAIN_UNITY) ? int'(GAIN_UNITY) : int'(c.gain);
               r.status = STATUS_NO_VOICE;
               for (int v = 0; v < NUM_VOICES; v++) begin
                  if (!v_active[v]) begin
                     v_sound[v] = c.sound_id;
                     v_pos[v] = 0;
                     v_loop[v] = c.repeat_req;
                     v_active[v] = 1;
                     r.status = STATUS_DONE;
                     break;
                  end
               end
            end
         end
         FUNC_STOP: begin
            if (!snd_valid[c.sound_id])
               r.status = STATUS_NO_SOUND;
            else
               for (int v = 0; v < NUM_VOICES; v++)
                  if (v_active[v] && v_sound[v] == c.sound_id) v_active[v] = 0;
         end
         FUNC_STOP_ALL: begin
            for (int v = 0; v < NUM_VOICES; v++) v_active[v] = 0;
         end
         FUNC_TICK: begin
            lsum = 0;
            rsum = 0;
            for (int v = 0; v < NUM_VOICES; v++) begin
               if (!v_active[v]) continue;
               pos = v_pos[v];
               if (pos >= snd_len[v_sound[v]]) begin
                  if (v_loop[v]) begin
                     pos = 0;
                  end else begin
                     v_active[v] = 0;
                     continue;
                  end
               end
               a = snd_start[v_sound[v]] + pos[ADDR_W-1:0];
               lsum += longint'($signed(store[a][31:16]));
               rsum += longint'($signed(store[a][15:0]));
               v_pos[v] = pos + 1'b1;
            end
            r.left = scale_channel(lsum);
            r.right = scale_channel(rsum);
         end
         default: ;
      endcase
      for (int v = 0; v < NUM_VOICES; v++) r.mask[v] = v_active[v];
      return r;
   endfunction

   // random gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one command and wait for its transfer
   task automatic send_cmd(cmd_type c);
      int gap;
      req_func <= c.func;
      req_address <= c.address;
      req_left_sample <= c.left_sample;
      req_right_sample <= c.right_sample;
      req_sound_id <= c.sound_id;
      req_frame_count <= c.frame_count;
      req_repeat_req <= c.repeat_req;
      req_volume <= c.gain;
      push <= 1;
      do @(posedge clock); while (full);
      pending_mix.push_back(mix_step(c));
      sent_count++;
      gap = sender_idle ? pick_gap() : 0;
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic cmd_type blank_cmd(func_type f);
      cmd_type c;
      c.func = f;
      c.address = ADDR_W'($urandom);
      c.left_sample = SAMPLE_W'($urandom);
      c.right_sample = SAMPLE_W'($urandom);
      c.sound_id = SID_W'($urandom);
      c.frame_count = LEN_W'($urandom);
      c.repeat_req = 1'($urandom);
      c.gain = GAIN_W'($urandom);
      return c;
   endfunction

   task automatic write_word(logic [ADDR_W-1:0] a, logic [15:0] l, logic [15:0] r);
      cmd_type c;
      c = blank_cmd(FUNC_WRITE);
      c.address = a;
      c.left_sample = l;
      c.right_sample = r;
      send_cmd(c);
   endtask

   task automatic define_sound(logic [SID_W-1:0] id, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] n);
      cmd_type c;
      c = blank_cmd(FUNC_DEFINE);
      c.sound_id = id;
      c.address = a;
      c.frame_count = n;
      send_cmd(c);
   endtask

   task automatic play_sound(logic [SID_W-1:0] id, bit rep, logic [GAIN_W-1:0] vol);
      cmd_type c;
      c = blank_cmd(FUNC_PLAY);
      c.sound_id = id;
      c.repeat_req = rep;
      c.gain = vol;
      send_cmd(c);
   endtask

   // tick, first writing every word this frame would read that is still unwritten
   task automatic tick_frame();
      logic [LEN_W-1:0] pos;
      logic [ADDR_W-1:0] a;
      for (int v = 0; v < NUM_VOICES; v++) begin
         if (!v_active[v]) continue;
         pos = v_pos[v];
         if (pos >= snd_len[v_sound[v]]) begin
            if (!v_loop[v]) continue;
            pos = 0;
         end
         a = snd_start[v_sound[v]] + pos[ADDR_W-1:0];
         if (!written[a]) write_word(a, 16'($urandom), 16'($urandom));
      end
      send_cmd(blank_cmd(FUNC_TICK));
   endtask

   function automatic logic [GAIN_W-1:0] pick_volume();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return GAIN_W'($urandom);
      if (r == 1) return GAIN_UNITY;
      return GAIN_W'($urandom_range(0, 32768));
   endfunction

   // extremes, every command and the corner cases
   task automatic test_directed();
      cmd_type c;
      play_sound(4'd3, 1'b0, GAIN_UNITY);               // play undefined
      c = blank_cmd(FUNC_STOP);
      c.sound_id = 4'd3;
      send_cmd(c);                                       // stop undefined
      send_cmd(blank_cmd(FUNC_NOP));
      send_cmd(blank_cmd(func_type'(FUNC_SPARE)));
      write_word(14'h3fff, 16'h7fff, 16'h8000);
      write_word(14'h0000, 16'h8000, 16'h7fff);
      define_sound(4'd15, 14'h3fff, 15'd2);              // wraps past the top
      play_sound(4'd15, 1'b1, 16'hffff);                 // gain above unity
      tick_frame();
      tick_frame();
      tick_frame();
      define_sound(4'd0, 14'h0000, 15'd0);               // zero length
      play_sound(4'd0, 1'b1, 16'd0);
      play_sound(4'd0, 1'b0, 16'd16384);
      tick_frame();
      tick_frame();
      for (int i = 0; i < 7; i++) play_sound(4'd15, 1'b1, GAIN_UNITY);  // last finds no voice
      tick_frame();
      c = blank_cmd(FUNC_STOP);
      c.sound_id = 4'd15;
      send_cmd(c);
      send_cmd(blank_cmd(FUNC_STOP_ALL));
   endtask

   // mostly well-formed playback sequences with random content
   task automatic test_random_mix();
      int first, r;
      logic [LEN_W-1:0] len;
      cmd_type c;
      first = sent_count;
      while (sent_count - first < RANDOM_ITEMS) begin
         if ($urandom_range(0, 199) == 0) sender_idle = !sender_idle;
         if ($urandom_range(0, 199) == 0) receiver_idle = !receiver_idle;
         r = $urandom_range(0, 99);
         if (r < 20) begin
            write_word(ADDR_W'($urandom), 16'($urandom), 16'($urandom));
         end else if (r < 28) begin
            case ($urandom_range(0, 9))
               0: len = 0;
               1: len = 15'd16384;
               2: len = LEN_W'($urandom_range(1, 16384));
               default: len = LEN_W'($urandom_range(1, 24));
            endcase
            define_sound(SID_W'($urandom), ADDR_W'($urandom), len);
         end else if (r < 43) begin
            play_sound(SID_W'($urandom), 1'($urandom), pick_volume());
         end else if (r < 49) begin
            c = blank_cmd(FUNC_STOP);
            send_cmd(c);
         end else if (r < 51) begin
            send_cmd(blank_cmd(FUNC_STOP_ALL));
         end else if (r < 54) begin
            send_cmd(blank_cmd($urandom_range(0, 1) ? FUNC_NOP : func_type'(FUNC_SPARE)));
         end else begin
            tick_frame();
         end
      end
   endtask

   // receiver stalls long while commands keep coming, so full must rise
   task automatic test_backpressure();
      pop_hold_req = 1;
      for (int i = 0; i < 30; i++)
         if (i % 3 == 0) tick_frame();
         else write_word(ADDR_W'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // result side: random or steady pop, with a long hold-off when the backpressure test asks for one
   always @(posedge clock) begin
      if (reset) begin
         pop <= 0;
      end else if (pop_hold_req) begin
         pop_hold_req <= 0;
         pop_hold <= 400;
         pop <= 0;
      end else if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         pop <= 0;
      end else if (receiver_idle) begin
         pop <= ($urandom_range(0, 99) < 65) ||
                ($urandom_range(0, 99) < 3 ? 1'b0 : 1'b0);
      end else begin
         pop <= 1;
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      mix_result_type e;
      if (!reset && pop && !empty) begin
         if (pending_mix.size() == 0) begin
            $display("%0t: unexpected result left=%0d right=%0d status=%0d mask=%h",
                     $time, rsp_left_out, rsp_right_out, rsp_status, rsp_active_mask);
            failed = 1;
         end else begin
            e = pending_mix.pop_front();
            if (rsp_left_out !== e.left) begin
               $display("%0t: left_out expected %0d actual %0d", $time, e.left, rsp_left_out);
               failed = 1;
            end
            if (rsp_right_out !== e.right) begin
               $display("%0t: right_out expected %0d actual %0d", $time, e.right,
                        rsp_right_out);
               failed = 1;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               failed = 1;
            end
            if (rsp_active_mask !== e.mask) begin
               $display("%0t: active_mask expected %h actual %h", $time, e.mask,
                        rsp_active_mask);
               failed = 1;
            end
         end
      end
   end

   initial begin
      for (int s = 0; s < SOUNDS; s++) snd_valid[s] = 0;
      for (int v = 0; v < NUM_VOICES; v++) begin
         v_active[v] = 0;
         v_loop[v] = 0;
         v_sound[v] = 0;
         v_pos[v] = 0;
      end
      gain = GAIN_UNITY;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_mix();
      push <= 0;
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (!failed)
         $display("** multi_voice_sample_mixer_core: PASSED **");
      else
         $display("** multi_voice_sample_mixer_core: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/mvsm_pkg.sv
rtl/core/mvsm_front.sv
rtl/core/mvsm_back.sv
rtl/core/multi_voice_sample_mixer_core.sv
tb/testbench.sv
